// ----- hdl/pulse_beat_detector_core_defines.svh -----
// Assertion macros for the pulse beat detector core.
// Needs nothing else; used by the core's top level.
`ifndef PULSE_BEAT_DETECTOR_CORE_DEFINES_SVH
`define PULSE_BEAT_DETECTOR_CORE_DEFINES_SVH

// Implication in the same cycle, checked outside reset.
`define PBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse beat detector: same-cycle check failed");

// Implication in the next cycle, checked outside reset.
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse beat detector: next-cycle check failed");

`endif

// ----- hdl/pbd_pkg.sv -----
// Shared constants for the pulse beat detector: widths, shifts, FIR coefficients
// and register indexes. No dependencies.
package pbd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int AC_W      = 16;
    localparam int DC_SHIFT  = 4;
    localparam int DC_ACC_W  = SAMPLE_W + DC_SHIFT;
    localparam int OUT_SHIFT = 14;

    localparam int HALF_TAPS = 5;
    localparam int NUM_TAPS  = 2 * HALF_TAPS + 1;
    localparam int COEF_W    = 13;
    localparam int PROD_W    = AC_W + COEF_W + 1;
    localparam int ACC_W     = 32;

    localparam logic [COEF_W-1:0] FIR_COEF [0:HALF_TAPS] = '{
        13'd321, 13'd927, 13'd1858, 13'd2916, 13'd3768, 13'd4096
    };

    localparam int THR_W     = 16;
    localparam int MAX_RST_W = 15;
    localparam int MIN_RST_W = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEAT_THRESHOLD = 2'd0,
        CFG_MAX_RESTART    = 2'd1,
        CFG_MIN_RESTART    = 2'd2
    } t_cfg_index;

    localparam logic [THR_W-1:0]            THR_RESET     = 16'd500;
    localparam logic [MAX_RST_W-1:0]        MAX_RST_RESET = 15'd500;
    localparam logic signed [MIN_RST_W-1:0] MIN_RST_RESET = -16'sd500;

endpackage

// ----- hdl/pulse_beat_detector_core.sv -----
// Pulse beat detector core: DC removal, 11-tap symmetric low-pass FIR and
// zero-crossing beat detection on a stream of 16-bit optical samples.
// Depends on pbd_pkg and pulse_beat_detector_core_defines.svh.
// Pipeline: a taken request passes the input reg, DC/tap stage, product stage,
//   sum stage and output reg. Throughput: one request per cycle while the result
//   stream is ready; each stage has its own valid bit, so bubbles close up under stall.
// Reset (i_rst_n low, synchronous): pipeline emptied, DC tracker, taps and
//   previous level cleared, registers back to 500/500/-500, running max/min reloaded.
`include "pulse_beat_detector_core_defines.svh"

module pulse_beat_detector_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,   // [15:0] sample
    // result stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,   // [15:0] ac_level
    output logic [0:0]                  o_m_axis_tuser,   // [0] beat
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pbd_pkg::CFG_W-1:0]   i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [pbd_pkg::THR_W-1:0]            r_thr;
    logic [pbd_pkg::MAX_RST_W-1:0]        r_max_rst;
    logic signed [pbd_pkg::MIN_RST_W-1:0] r_min_rst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= pbd_pkg::THR_RESET;
            r_max_rst <= pbd_pkg::MAX_RST_RESET;
            r_min_rst <= pbd_pkg::MIN_RST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbd_pkg::CFG_BEAT_THRESHOLD: r_thr     <= i_cfg_data[pbd_pkg::THR_W-1:0];
                pbd_pkg::CFG_MAX_RESTART:    r_max_rst <= i_cfg_data[pbd_pkg::MAX_RST_W-1:0];
                pbd_pkg::CFG_MIN_RESTART:    r_min_rst <= i_cfg_data[pbd_pkg::MIN_RST_W-1:0];
                default: ; // unused index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage valids and the ready chain. Stage k takes a new request when it
    // is empty or its content moves on in the same cycle.
    // ---------------------------------------------------------------
    logic r0_v, r1_v, r2_v, r3_v, r_out_valid;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic mv0, mv1, mv2, mv3, in_take;

    always_comb begin
        rdy4    = !r_out_valid || i_m_axis_tready;
        rdy3    = !r3_v || rdy4;
        rdy2    = !r2_v || rdy3;
        rdy1    = !r1_v || rdy2;
        rdy0    = !r0_v || rdy1;
        in_take = i_s_axis_tvalid && rdy0;
        mv0     = r0_v && rdy1;
        mv1     = r1_v && rdy2;
        mv2     = r2_v && rdy3;
        mv3     = r3_v && rdy4;
    end

    assign o_s_axis_tready = rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v        <= 1'b0;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy0) r0_v        <= i_s_axis_tvalid;
            if (rdy1) r1_v        <= r0_v;
            if (rdy2) r2_v        <= r1_v;
            if (rdy3) r3_v        <= r2_v;
            if (rdy4) r_out_valid <= r3_v;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------
    logic [pbd_pkg::SAMPLE_W-1:0] r0_x;

    always_ff @(posedge i_clk) begin
        if (in_take) r0_x <= i_s_axis_tdata[pbd_pkg::SAMPLE_W-1:0];
    end

    // ---------------------------------------------------------------
    // Stage 1: DC tracker and tap line. The accumulator moves by the error
    // over 2^DC_SHIFT, floored (arithmetic shift). Taps hold the last eleven
    // AC values, newest in tap 0; older values shift out past tap 10 and never reach the FIR.
    // ---------------------------------------------------------------
    logic [pbd_pkg::DC_ACC_W-1:0]         r_dc;
    logic [pbd_pkg::DC_ACC_W-1:0]         n_dc;
    logic signed [pbd_pkg::DC_ACC_W+1:0]  dc_err;
    logic signed [pbd_pkg::DC_ACC_W+1:0]  dc_sum;
    logic [pbd_pkg::SAMPLE_W-1:0]         dc_est;
    logic [pbd_pkg::AC_W-1:0]             n_ac;
    logic [pbd_pkg::AC_W-1:0]             r_tap [0:pbd_pkg::NUM_TAPS-1];

    always_comb begin
        dc_err = $signed({2'b00, r0_x, {pbd_pkg::DC_SHIFT{1'b0}}})
               - $signed({2'b00, r_dc});
        dc_sum = $signed({2'b00, r_dc}) + (dc_err >>> pbd_pkg::DC_SHIFT);
        n_dc   = dc_sum[pbd_pkg::DC_ACC_W-1:0];
        dc_est = n_dc[pbd_pkg::DC_ACC_W-1:pbd_pkg::DC_SHIFT];
        n_ac   = r0_x - dc_est; // 16-bit wrap
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc <= '0;
            for (int k = 0; k < pbd_pkg::NUM_TAPS; k++) r_tap[k] <= '0;
        end else if (mv0) begin
            r_dc     <= n_dc;
            r_tap[0] <= n_ac;
            for (int k = 1; k < pbd_pkg::NUM_TAPS; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: wrapped pair sums times constant coefficients
    // ---------------------------------------------------------------
    logic signed [pbd_pkg::AC_W-1:0]   pair [0:pbd_pkg::HALF_TAPS];
    logic signed [pbd_pkg::PROD_W-1:0] n_prod [0:pbd_pkg::HALF_TAPS];
    logic signed [pbd_pkg::PROD_W-1:0] r2_prod [0:pbd_pkg::HALF_TAPS];

    always_comb begin
        for (int k = 0; k < pbd_pkg::HALF_TAPS; k++) begin
            pair[k] = $signed(r_tap[k] + r_tap[pbd_pkg::NUM_TAPS-1-k]);
        end
        pair[pbd_pkg::HALF_TAPS] = $signed(r_tap[pbd_pkg::HALF_TAPS]);
        for (int k = 0; k <= pbd_pkg::HALF_TAPS; k++) begin
            n_prod[k] = pbd_pkg::PROD_W'(pair[k] * $signed({1'b0, pbd_pkg::FIR_COEF[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            for (int k = 0; k <= pbd_pkg::HALF_TAPS; k++) r2_prod[k] <= n_prod[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: sum of products, floor shift, wrap to 16 bits
    // ---------------------------------------------------------------
    logic signed [pbd_pkg::ACC_W-1:0] fir_sum;
    logic signed [pbd_pkg::ACC_W-1:0] fir_shifted;
    logic signed [pbd_pkg::AC_W-1:0]  r3_ac;

    always_comb begin
        fir_sum = '0;
        for (int k = 0; k <= pbd_pkg::HALF_TAPS; k++) begin
            fir_sum = fir_sum + pbd_pkg::ACC_W'(r2_prod[k]);
        end
        fir_shifted = fir_sum >>> pbd_pkg::OUT_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (mv2) r3_ac <= fir_shifted[pbd_pkg::AC_W-1:0];
    end

    // ---------------------------------------------------------------
    // Stage 4: beat detection on an upward zero crossing, output register.
    // Spread is taken two bits wider than its operands so it cannot wrap.
    // ---------------------------------------------------------------
    logic signed [pbd_pkg::AC_W-1:0] r_prev;
    logic signed [pbd_pkg::AC_W-1:0] r_run_max;
    logic signed [pbd_pkg::AC_W-1:0] r_run_min;
    logic signed [pbd_pkg::AC_W-1:0] cand_max;
    logic signed [pbd_pkg::AC_W-1:0] cand_min;
    logic signed [pbd_pkg::AC_W+1:0] spread;
    logic                            crossing;
    logic                            n_beat;
    logic [pbd_pkg::AC_W-1:0]        r_out_ac;
    logic                            r_out_beat;

    always_comb begin
        crossing = r_prev[pbd_pkg::AC_W-1] && !r3_ac[pbd_pkg::AC_W-1];
        cand_max = (crossing && (r3_ac > r_run_max)) ? r3_ac : r_run_max;
        cand_min = (crossing && (r3_ac < r_run_min)) ? r3_ac : r_run_min;
        spread   = (pbd_pkg::AC_W+2)'(cand_max) - (pbd_pkg::AC_W+2)'(cand_min);
        n_beat   = crossing && (spread > $signed({2'b00, r_thr}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_run_max <= $signed({1'b0, pbd_pkg::MAX_RST_RESET});
            r_run_min <= pbd_pkg::MIN_RST_RESET;
        end else if (mv3) begin
            r_prev <= r3_ac;
            if (n_beat) begin
                r_run_max <= $signed({1'b0, r_max_rst});
                r_run_min <= r_min_rst;
            end else begin
                r_run_max <= cand_max;
                r_run_min <= cand_min;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_out_ac   <= r3_ac;
            r_out_beat <= n_beat;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_ac;
    assign o_m_axis_tuser[0] = r_out_beat;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // a beat only fires on a non-negative filtered level
    `PBD_ASSERT_SAME(a_beat_nonneg, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], !o_m_axis_tdata[15])
    // a refused request means the back end really is blocked
    `PBD_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready)
    // after a beat the running extremes sit at their restart values
    `PBD_ASSERT_NEXT(a_beat_restart, i_clk, i_rst_n, mv3 && n_beat, (r_run_max == $signed({1'b0, r_max_rst})) && (r_run_min == r_min_rst))

endmodule
